// ----- rtl/core/qoisd_pkg.sv -----
// Shared types, codes and helper functions for the QOI stream decoder.
package qoisd_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [31:0] pixel_argb;
        logic [31:0] image_width;
        logic [31:0] image_height;
        logic [2:0]  status_code;
        logic        last_of_burst;
    } out_item_t;

    localparam logic [1:0] KIND_PIXEL    = 2'd0;
    localparam logic [1:0] KIND_HEADER   = 2'd1;
    localparam logic [1:0] KIND_COMPLETE = 2'd2;
    localparam logic [1:0] KIND_ERROR    = 2'd3;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_TRUNCATED   = 3'd1;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd2;
    localparam logic [2:0] ST_CORRUPT     = 3'd3;
    localparam logic [2:0] ST_LIMIT       = 3'd4;

    localparam logic [1:0] CFG_WIDTH_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT_LIMIT = 2'd1;
    localparam logic [1:0] CFG_BYTES_LIMIT  = 2'd2;

    // Work commands passed from the front to the back.
    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_HEADER  = 3'd1;
    localparam logic [2:0] CMD_SETCHAN = 3'd2;
    localparam logic [2:0] CMD_LUMA    = 3'd3;
    localparam logic [2:0] CMD_DIFF    = 3'd4;
    localparam logic [2:0] CMD_INDEX   = 3'd5;
    localparam logic [2:0] CMD_RUN     = 3'd6;

    localparam logic [1:0] TAIL_NONE  = 2'd0;
    localparam logic [1:0] TAIL_DONE  = 2'd1;
    localparam logic [1:0] TAIL_ERROR = 2'd2;

    localparam logic [7:0] OP_RGB  = 8'hFE;
    localparam logic [7:0] OP_RGBA = 8'hFF;
    localparam logic [1:0] TAG_INDEX = 2'b00;
    localparam logic [1:0] TAG_DIFF  = 2'b01;
    localparam logic [1:0] TAG_LUMA  = 2'b10;
    localparam logic [1:0] TAG_RUN   = 2'b11;

    localparam int FIFO_DEPTH = 2;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  data;
        logic [5:0]  aux;
        logic [5:0]  count;
        logic [1:0]  tail;
        logic [2:0]  status;
        logic        four;
        logic [31:0] width;
        logic [31:0] height;
    } qent_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] m;
        unique case (idx)
            2'd0:    m = 8'h71;
            2'd1:    m = 8'h6F;
            2'd2:    m = 8'h69;
            default: m = 8'h66;
        endcase
        return m;
    endfunction

    function automatic logic [5:0] hash_slot(input logic [31:0] p);
        logic [5:0] h;
        h = 6'(p[23:16] * 3) + 6'(p[15:8] * 5) + 6'(p[7:0] * 7) + 6'(p[31:24] * 11);
        return h;
    endfunction

endpackage

// ----- rtl/core/qoisd_fifo.sv -----
// Short command queue between the front and the back.
module qoisd_fifo
    import qoisd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  qent_t push_data,
    input  logic  pop,
    output qent_t head,
    output logic  full,
    output logic  empty
);
    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    qent_t          store_reg [FIFO_DEPTH];
    logic [PW-1:0]  wr_reg, rd_reg;
    logic [CW-1:0]  cnt_reg;

    assign full  = (cnt_reg == CW'(FIFO_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = store_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == PW'(FIFO_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == PW'(FIFO_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + CW'(push) - CW'(pop);
        end
    end
endmodule

// ----- rtl/core/qoisd_front.sv -----
// Byte intake: header checks, padding delay line, chunk framing and pixel count.
module qoisd_front
    import qoisd_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  in_item_t    item,
    input  logic [31:0] width_limit,
    input  logic [31:0] height_limit,
    input  logic [31:0] max_bytes,
    output logic        push,
    output qent_t       ent
);
    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_DATA   = 2'd1;
    localparam logic [1:0] PH_DRAIN  = 2'd2;

    logic [1:0]             phase_reg, phase_next;
    logic [3:0]             hc_reg, hc_next;
    logic [31:0]            width_reg, width_next;
    logic [31:0]            height_reg, height_next;
    logic                   four_reg, four_next;
    logic [7:0]             delay_reg [8];
    logic [7:0]             delay_next [8];
    logic [3:0]             fill_reg, fill_next;
    logic [7:0]             op_reg, op_next;
    logic [2:0]             pend_reg, pend_next;
    logic [COUNT_WIDTH-1:0] left_reg, left_next;
    logic [63:0]            prod_reg;

    logic       restart;
    logic [7:0] b, old;
    logic [6:0] run;
    logic [2:0] total;
    logic       pad_ok;

    always_ff @(posedge clk)
    begin
        prod_reg <= width_reg * height_reg;
    end

    always_comb
    begin
        phase_next  = phase_reg;
        hc_next     = hc_reg;
        width_next  = width_reg;
        height_next = height_reg;
        four_next   = four_reg;
        delay_next  = delay_reg;
        fill_next   = fill_reg;
        op_next     = op_reg;
        pend_next   = pend_reg;
        left_next   = left_reg;
        restart     = 1'b0;
        push        = 1'b0;
        ent         = '0;
        b           = item.in_byte;
        old         = delay_reg[0];
        run         = {1'b0, old[5:0]} + 7'd1;
        total       = (op_reg == OP_RGB) ? 3'd3 : 3'd4;
        pad_ok      = 1'b0;
        if (take)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    hc_next = hc_reg + 4'd1;
                    if (item.last_byte)
                    begin
                        push       = 1'b1;
                        ent.tail   = TAIL_ERROR;
                        ent.status = ST_TRUNCATED;
                        restart    = 1'b1;
                    end
                    else if (hc_reg < 4'd4)
                    begin
                        if (b != magic_byte(hc_reg[1:0]))
                        begin
                            push       = 1'b1;
                            ent.tail   = TAIL_ERROR;
                            ent.status = ST_UNSUPPORTED;
                            phase_next = PH_DRAIN;
                        end
                    end
                    else if (hc_reg < 4'd8)
                    begin
                        width_next = {width_reg[23:0], b};
                    end
                    else if (hc_reg < 4'd12)
                    begin
                        height_next = {height_reg[23:0], b};
                    end
                    else if (hc_reg == 4'd12)
                    begin
                        if (width_reg == '0 || height_reg == '0 || (b != 8'd3 && b != 8'd4))
                        begin
                            push       = 1'b1;
                            ent.tail   = TAIL_ERROR;
                            ent.status = ST_CORRUPT;
                            phase_next = PH_DRAIN;
                        end
                        else
                        begin
                            four_next = (b == 8'd4);
                        end
                    end
                    else
                    begin
                        push = 1'b1;
                        if (b > 8'd1)
                        begin
                            ent.tail   = TAIL_ERROR;
                            ent.status = ST_CORRUPT;
                            phase_next = PH_DRAIN;
                        end
                        else if (width_reg > width_limit || height_reg > height_limit
                                 || prod_reg > {32'd0, 2'b00, max_bytes[31:2]}
                                 || (prod_reg >> COUNT_WIDTH) != '0)
                        begin
                            ent.tail   = TAIL_ERROR;
                            ent.status = ST_LIMIT;
                            phase_next = PH_DRAIN;
                        end
                        else
                        begin
                            ent.cmd    = CMD_HEADER;
                            ent.four   = four_reg;
                            ent.width  = width_reg;
                            ent.height = height_reg;
                            left_next  = prod_reg[COUNT_WIDTH-1:0];
                            fill_next  = '0;
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    if (fill_reg < 4'd8)
                    begin
                        delay_next[fill_reg[2:0]] = b;
                        fill_next = fill_reg + 4'd1;
                    end
                    else
                    begin
                        for (int i = 0; i < 7; i++)
                        begin
                            delay_next[i] = delay_reg[i+1];
                        end
                        delay_next[7] = b;
                        ent.data = old;
                        if (left_reg != '0)
                        begin
                            if (pend_reg != '0)
                            begin
                                if (op_reg == OP_RGB || op_reg == OP_RGBA)
                                begin
                                    ent.cmd   = CMD_SETCHAN;
                                    ent.aux   = {4'd0, 2'(total - pend_reg)};
                                    pend_next = pend_reg - 3'd1;
                                    if (pend_reg == 3'd1)
                                    begin
                                        ent.count = 6'd1;
                                    end
                                end
                                else
                                begin
                                    ent.cmd   = CMD_LUMA;
                                    ent.aux   = op_reg[5:0];
                                    ent.count = 6'd1;
                                    pend_next = '0;
                                    op_next   = '0;
                                end
                            end
                            else if (old == OP_RGB || old == OP_RGBA)
                            begin
                                op_next   = old;
                                pend_next = (old == OP_RGB) ? 3'd3 : 3'd4;
                            end
                            else
                            begin
                                unique case (old[7:6])
                                    TAG_INDEX:
                                    begin
                                        ent.cmd   = CMD_INDEX;
                                        ent.count = 6'd1;
                                    end
                                    TAG_DIFF:
                                    begin
                                        ent.cmd   = CMD_DIFF;
                                        ent.count = 6'd1;
                                    end
                                    TAG_LUMA:
                                    begin
                                        op_next   = old;
                                        pend_next = 3'd1;
                                    end
                                    default:
                                    begin
                                        ent.cmd   = CMD_RUN;
                                        ent.count = (left_reg < COUNT_WIDTH'(run))
                                                    ? left_reg[5:0] : run[5:0];
                                    end
                                endcase
                            end
                            left_next = left_reg - COUNT_WIDTH'(ent.count);
                        end
                        push = (ent.cmd != CMD_NONE);
                    end
                    if (item.last_byte)
                    begin
                        pad_ok = 1'b1;
                        for (int i = 0; i < 7; i++)
                        begin
                            pad_ok = pad_ok && (delay_next[i] == 8'd0);
                        end
                        pad_ok = pad_ok && (delay_next[7] == 8'd1);
                        push = 1'b1;
                        ent.tail = TAIL_ERROR;
                        if (fill_next < 4'd8)
                        begin
                            ent.status = ST_TRUNCATED;
                        end
                        else if (!pad_ok)
                        begin
                            ent.status = ST_CORRUPT;
                        end
                        else if (left_next != '0)
                        begin
                            ent.status = ST_TRUNCATED;
                        end
                        else
                        begin
                            ent.tail = TAIL_DONE;
                        end
                        restart = 1'b1;
                    end
                end
                default:
                begin
                    restart = item.last_byte;
                end
            endcase
        end
        if (restart)
        begin
            phase_next  = PH_HEADER;
            hc_next     = '0;
            width_next  = '0;
            height_next = '0;
            four_next   = 1'b0;
            fill_next   = '0;
            op_next     = '0;
            pend_next   = '0;
            left_next   = '0;
            for (int i = 0; i < 8; i++)
            begin
                delay_next[i] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            hc_reg     <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            four_reg   <= 1'b0;
            fill_reg   <= '0;
            op_reg     <= '0;
            pend_reg   <= '0;
            left_reg   <= '0;
            for (int i = 0; i < 8; i++)
            begin
                delay_reg[i] <= '0;
            end
        end
        else
        begin
            phase_reg  <= phase_next;
            hc_reg     <= hc_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            four_reg   <= four_next;
            fill_reg   <= fill_next;
            op_reg     <= op_next;
            pend_reg   <= pend_next;
            left_reg   <= left_next;
            delay_reg  <= delay_next;
        end
    end
endmodule

// ----- rtl/core/qoisd_back.sv -----
// Pixel engine: colour arithmetic, colour index memory and result emission.
module qoisd_back
    import qoisd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      empty,
    input  qent_t     head,
    output logic      pop,
    input  logic      out_ready,
    output logic      out_valid,
    output out_item_t out_data
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_PIX  = 3'd2;
    localparam logic [2:0] S_TAIL = 3'd3;
    localparam logic [2:0] S_HDR  = 3'd4;

    logic [2:0]  state_reg, state_next;
    qent_t       cur_reg, cur_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] pix_reg, pix_next;
    logic        four_reg, four_next;
    logic [63:0] vld_reg;
    logic [31:0] mem [64];
    logic [31:0] rd_data_reg;
    logic        rd_vld_reg;
    logic        ov_reg;
    out_item_t   od_reg, od_next;
    logic        emit, can_emit, mem_we, vld_clear;
    logic [5:0]  wa;
    logic [7:0]  r, g, bl, hb;

    assign can_emit  = !ov_reg || out_ready;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    assign wa        = hash_slot(pix_reg);

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        cnt_next   = cnt_reg;
        pix_next   = pix_reg;
        four_next  = four_reg;
        pop        = 1'b0;
        emit       = 1'b0;
        mem_we     = 1'b0;
        vld_clear  = 1'b0;
        od_next    = '0;
        r          = pix_reg[23:16];
        g          = pix_reg[15:8];
        bl         = pix_reg[7:0];
        hb         = head.data;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    pop      = 1'b1;
                    cur_next = head;
                    cnt_next = head.count;
                    unique case (head.cmd)
                        CMD_SETCHAN:
                        begin
                            unique case (head.aux[1:0])
                                2'd0:    pix_next[23:16] = hb;
                                2'd1:    pix_next[15:8]  = hb;
                                2'd2:    pix_next[7:0]   = hb;
                                default: pix_next[31:24] = hb;
                            endcase
                        end
                        CMD_LUMA:
                        begin
                            pix_next[23:16] = r + {2'b0, head.aux} + {4'b0, hb[7:4]} - 8'd40;
                            pix_next[15:8]  = g + {2'b0, head.aux} - 8'd32;
                            pix_next[7:0]   = bl + {2'b0, head.aux} + {4'b0, hb[3:0]} - 8'd40;
                        end
                        CMD_DIFF:
                        begin
                            pix_next[23:16] = r + {6'b0, hb[5:4]} - 8'd2;
                            pix_next[15:8]  = g + {6'b0, hb[3:2]} - 8'd2;
                            pix_next[7:0]   = bl + {6'b0, hb[1:0]} - 8'd2;
                        end
                        default:
                        begin
                        end
                    endcase
                    if (head.cmd == CMD_HEADER)
                    begin
                        state_next = S_HDR;
                    end
                    else if (head.cmd == CMD_INDEX)
                    begin
                        state_next = S_RD;
                    end
                    else if (head.count != '0)
                    begin
                        state_next = S_PIX;
                    end
                    else if (head.tail != TAIL_NONE)
                    begin
                        state_next = S_TAIL;
                    end
                end
            end
            S_RD:
            begin
                pix_next   = rd_vld_reg ? rd_data_reg : '0;
                state_next = S_PIX;
            end
            S_PIX:
            begin
                if (can_emit)
                begin
                    emit    = 1'b1;
                    mem_we  = 1'b1;
                    od_next.result_kind   = KIND_PIXEL;
                    od_next.pixel_argb    = four_reg ? pix_reg : (pix_reg | 32'hFF00_0000);
                    od_next.last_of_burst = (cnt_reg == 6'd1) && (cur_reg.tail == TAIL_NONE);
                    cnt_next = cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1)
                    begin
                        state_next = (cur_reg.tail != TAIL_NONE) ? S_TAIL : S_IDLE;
                    end
                end
            end
            S_TAIL:
            begin
                if (can_emit)
                begin
                    emit = 1'b1;
                    od_next.result_kind   = (cur_reg.tail == TAIL_DONE) ? KIND_COMPLETE
                                                                        : KIND_ERROR;
                    od_next.status_code   = cur_reg.status;
                    od_next.last_of_burst = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_HDR:
            begin
                if (can_emit)
                begin
                    emit      = 1'b1;
                    vld_clear = 1'b1;
                    pix_next  = 32'hFF00_0000;
                    four_next = cur_reg.four;
                    od_next.result_kind   = KIND_HEADER;
                    od_next.image_width   = cur_reg.width;
                    od_next.image_height  = cur_reg.height;
                    od_next.last_of_burst = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wa] <= pix_reg;
        end
        rd_data_reg <= mem[head.data[5:0]];
        cur_reg     <= cur_next;
        cnt_reg     <= cnt_next;
        if (emit)
        begin
            od_reg <= od_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pix_reg    <= 32'hFF00_0000;
            four_reg   <= 1'b0;
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pix_reg    <= pix_next;
            four_reg   <= four_next;
            rd_vld_reg <= vld_reg[head.data[5:0]];
            if (vld_clear)
            begin
                vld_reg <= '0;
            end
            else if (mem_we)
            begin
                vld_reg[wa] <= 1'b1;
            end
            if (emit)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end
endmodule

// ----- rtl/core/qoi_image_stream_decoder.sv -----
// Top level of the QOI image stream decoder: config registers, front, queue, back.
//
// Usage: feed the encoded file on the input channel one byte per transaction,
// header first, with last_byte set on the final byte. The decoder answers on
// the output channel with one header transaction after a valid 14-byte header,
// one ARGB pixel transaction per decoded pixel, and one closing transaction
// (image complete or error) per file; last_of_burst marks the final result
// caused by one input byte. Limits are written on the cfg channel (index 0
// width limit, 1 height limit, 2 output byte limit) while the decoder is idle.
// Chunk bytes go through an 8-byte delay line that holds back the padding,
// so a chunk decodes when the eighth byte after it arrives; its command then
// passes through the queue and the back (an index chunk also waits on the
// colour index memory read) before its pixels reach the output register.
// Throughput: the front takes one byte per cycle while the queue has room;
// the back takes a new command only once every result of the last one is out.
// Reset clears all control state, the colour index valid bits and the limits
// to their defaults. When the receiver stalls, the output register holds, the
// back stops, the queue fills and in_ready drops until results drain.
module qoi_image_stream_decoder
    import qoisd_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    logic [31:0] width_limit_reg, height_limit_reg, max_bytes_reg;
    logic        take, push, pop, full, empty;
    qent_t       push_ent, head;

    // Accept a byte only when the queue can hold whatever it produces.
    assign in_ready  = !full;
    assign take      = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_limit_reg  <= 32'd16384;
            height_limit_reg <= 32'd16384;
            max_bytes_reg    <= 32'd268435456;
        end
        else if (cfg_valid)
        begin
            // Drop writes to indexes beyond the register list.
            unique case (cfg_index)
                CFG_WIDTH_LIMIT:  width_limit_reg  <= cfg_data;
                CFG_HEIGHT_LIMIT: height_limit_reg <= cfg_data;
                CFG_BYTES_LIMIT:  max_bytes_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    qoisd_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .item         (in_data),
        .width_limit  (width_limit_reg),
        .height_limit (height_limit_reg),
        .max_bytes    (max_bytes_reg),
        .push         (push),
        .ent          (push_ent)
    );

    qoisd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_ent),
        .pop       (pop),
        .head      (head),
        .full      (full),
        .empty     (empty)
    );

    qoisd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .head      (head),
        .pop       (pop),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    // The front pushes only on an accepted byte, which needs queue room.
    assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("command pushed into full queue");

    // The back never pops a command from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("command popped from empty queue");

    // An error result always carries a nonzero status, other kinds a zero one.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_data.result_kind == KIND_ERROR) == (out_data.status_code != ST_OK)))
        else $error("status code does not match result kind");

    // A header result reports a nonzero image size.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.result_kind == KIND_HEADER
        |-> out_data.image_width != '0 && out_data.image_height != '0)
        else $error("header result with zero size");
endmodule
